// File: hdl/tlbc_pkg.sv
// Package for the token lexer with brace check: kinds, error codes, limits,
// keyword table and character class functions. No dependencies.
package tlbc_pkg;

    localparam int MaxIdChars   = 10;
    localparam int MaxIntDigits = 8;
    localparam int MaxStrChars  = 256;
    localparam int MaxNesting   = 255;

    typedef enum logic [3:0] {
        K_IDENT   = 4'd0,
        K_INT     = 4'd1,
        K_OPER    = 4'd2,
        K_LBRACE  = 4'd3,
        K_RBRACE  = 4'd4,
        K_STRING  = 4'd5,
        K_KEYWORD = 4'd6,
        K_EOL     = 4'd7,
        K_COMMA   = 4'd8,
        K_END     = 4'd9,
        K_ERROR   = 4'd10
    } t_kind;

    typedef enum logic [3:0] {
        E_NONE     = 4'd0,
        E_ID_LONG  = 4'd1,
        E_INT_LONG = 4'd2,
        E_COMMENT  = 4'd3,
        E_STR_OPEN = 4'd4,
        E_STR_LONG = 4'd5,
        E_BAD_CHAR = 4'd6,
        E_BRACE    = 4'd7,
        E_NEST     = 4'd8
    } t_err;

    // One emitted word: kind, character, last flag, error code
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       last;
        t_err       err;
    } t_tok;

    function automatic logic f_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic f_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic f_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // Keyword text, packed first character in the top byte, padded with zero
    function automatic logic [55:0] f_kw_text(input logic [2:0] k);
        logic [55:0] t;
        unique case (k)
            3'd0: t = {"int", 32'h0};
            3'd1: t = {"text", 24'h0};
            3'd2: t = {"is", 40'h0};
            3'd3: t = {"loop", 24'h0};
            3'd4: t = {"times", 16'h0};
            3'd5: t = {"read", 24'h0};
            3'd6: t = {"write", 16'h0};
            default: t = "newLine";
        endcase
        return t;
    endfunction

    function automatic logic [2:0] f_kw_len(input logic [2:0] k);
        logic [2:0] l;
        unique case (k)
            3'd0: l = 3'd3;
            3'd1: l = 3'd4;
            3'd2: l = 3'd2;
            3'd3: l = 3'd4;
            3'd4: l = 3'd5;
            3'd5: l = 3'd4;
            3'd6: l = 3'd5;
            default: l = 3'd7;
        endcase
        return l;
    endfunction

endpackage

// File: hdl/tlbc_wordmem.sv
// Word buffer memory of the lexer: one write port, one registered read port.
// Depends on nothing.
module tlbc_wordmem #(
    parameter int Depth = 10,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [Depth];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hdl/token_lexer_with_brace_check_top.sv
// Token lexer with brace check.
// Input channel: i_in_byte and i_end_of_input with i_in_valid, accepted when
// i_in_valid is high and o_in_stall low. Output channel: one word per
// character of a token (o_token_kind, o_value_char, o_last_char,
// o_error_code) with o_out_valid, taken when i_out_stall is low.
// An input word that gives at most one output word is taken when the output
// is free; its output word is registered and valid the cycle after. The next
// byte may enter at the edge where the output word leaves; a stalled output
// word holds and stalls the input.
// Ending an identifier or integer within its length limit replays the word
// buffer memory: a read pending state, then one character a cycle while the
// output is free, then the held terminator byte; the input stalls until the
// terminator is replayed. A byte after a lone slash is held the same way and
// stalls the input until it is replayed. The keyword check runs on the
// characters as they are written, so no extra pass is needed.
// End of input emits the end word (or an error); any error emits one error
// word. After either the block takes input but emits nothing until reset.
// Reset (synchronous, low) returns to idle with zero depth and no pending
// word.
// Depends on tlbc_pkg and tlbc_wordmem.
module token_lexer_with_brace_check_top #(
    parameter int MAX_ID_CHARS   = tlbc_pkg::MaxIdChars,
    parameter int MAX_INT_DIGITS = tlbc_pkg::MaxIntDigits,
    parameter int MAX_STR_CHARS  = tlbc_pkg::MaxStrChars,
    parameter int MAX_NESTING    = tlbc_pkg::MaxNesting
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_value_char,
    output logic       o_last_char,
    output logic [3:0] o_error_code
);
    import tlbc_pkg::*;

    localparam int Depth = (MAX_ID_CHARS > MAX_INT_DIGITS) ? MAX_ID_CHARS : MAX_INT_DIGITS;
    localparam int AW    = $clog2(Depth);
    localparam int LW    = $clog2(Depth + 2);
    localparam int SW    = $clog2(MAX_STR_CHARS + 2);
    localparam int BW    = $clog2(MAX_NESTING + 1);

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_INT, M_SLASH, M_COMMENT, M_STAR, M_STRING
    } t_mode;

    // flush sequencer: idle, read pending, streaming
    typedef enum logic [1:0] {F_OFF, F_READ, F_RUN} t_fl;

    t_mode          r_mode, n_mode;
    t_fl            r_fl, n_fl;
    logic [LW-1:0]  r_wlen, n_wlen;
    logic [SW-1:0]  r_slen, n_slen;
    logic [BW-1:0]  r_depth, n_depth;
    logic           r_halt, n_halt;
    logic [7:0]     r_kwm, n_kwm;       // keywords still matching
    logic           r_fkw, n_fkw;       // flush kind is keyword
    logic           r_fint, n_fint;     // flush kind is integer
    logic [LW-1:0]  r_fidx, n_fidx;     // index of the character in rdata
    logic [LW-1:0]  r_flen, n_flen;
    logic [7:0]     r_pb, n_pb;         // held terminator byte
    logic           r_peof, n_peof;
    logic           r_ov, n_ov;
    t_tok           r_o, n_o;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [7:0]     wdata;
    logic [7:0]     rdata;

    tlbc_wordmem #(.Depth(Depth), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic out_free, acc;
    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = !out_free || (r_fl != F_OFF) || (r_pb != 8'd0) || r_peof;
    assign acc        = i_in_valid && !o_in_stall;

    assign o_out_valid  = r_ov;
    assign o_token_kind = r_o.kind;
    assign o_value_char = r_o.ch;
    assign o_last_char  = r_o.last;
    assign o_error_code = r_o.err;

    function automatic t_tok mk(input t_kind k, input logic [7:0] c, input logic l,
                                input t_err e);
        t_tok t;
        t.kind = k; t.ch = c; t.last = l; t.err = e;
        return t;
    endfunction

    // keyword match vector update for a character at position p
    function automatic logic [7:0] kw_step(input logic [7:0] m, input logic [LW-1:0] p,
                                           input logic [7:0] b);
        logic [7:0]  r;
        logic [55:0] t;
        r = m;
        for (int k = 0; k < 8; k++) begin
            t = f_kw_text(3'(k));
            if (p >= LW'(7)) begin
                r[k] = 1'b0;
            end else if (t[55 - 8*int'(p[2:0]) -: 8] != b) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic kw_hit(input logic [7:0] m, input logic [LW-1:0] l);
        logic h;
        h = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (m[k] && (l == LW'(f_kw_len(3'(k))))) begin
                h = 1'b1;
            end
        end
        return h;
    endfunction

    // handle a byte from idle; sets output word if any
    task automatic idle_byte(input logic [7:0] b, input logic eof,
                             inout t_mode md, inout logic hl, inout logic [BW-1:0] dp,
                             inout logic [SW-1:0] sl, inout logic [LW-1:0] wl,
                             inout logic [7:0] km, inout logic ov, inout t_tok o,
                             inout logic w);
        md = M_IDLE;
        if (eof) begin
            hl = 1'b1;
            ov = 1'b1;
            o = (dp != '0) ? mk(K_ERROR, 8'd0, 1'b1, E_BRACE) : mk(K_END, 8'd0, 1'b1, E_NONE);
        end else if (f_space(b)) begin
            md = M_IDLE;
        end else if (f_alpha(b) || f_digit(b)) begin
            md = f_alpha(b) ? M_IDENT : M_INT;
            wl = LW'(1);
            w  = 1'b1;
            km = kw_step(8'hff, '0, b);
        end else begin
            priority case (b)
                8'h2f: md = M_SLASH;
                8'h2b, 8'h2d, 8'h2a: begin
                    ov = 1'b1; o = mk(K_OPER, b, 1'b1, E_NONE);
                end
                8'h7b: begin
                    ov = 1'b1;
                    if (dp >= BW'(MAX_NESTING)) begin
                        hl = 1'b1; o = mk(K_ERROR, 8'd0, 1'b1, E_NEST);
                    end else begin
                        dp = dp + 1'b1; o = mk(K_LBRACE, b, 1'b1, E_NONE);
                    end
                end
                8'h7d: begin
                    ov = 1'b1;
                    if (dp == '0) begin
                        hl = 1'b1; o = mk(K_ERROR, 8'd0, 1'b1, E_BRACE);
                    end else begin
                        dp = dp - 1'b1; o = mk(K_RBRACE, b, 1'b1, E_NONE);
                    end
                end
                8'h22: begin
                    sl = '0; md = M_STRING; ov = 1'b1;
                    o = mk(K_STRING, b, 1'b0, E_NONE);
                end
                8'h2e: begin
                    ov = 1'b1; o = mk(K_EOL, b, 1'b1, E_NONE);
                end
                8'h2c: begin
                    ov = 1'b1; o = mk(K_COMMA, b, 1'b1, E_NONE);
                end
                default: begin
                    hl = 1'b1; ov = 1'b1; o = mk(K_ERROR, 8'd0, 1'b1, E_BAD_CHAR);
                end
            endcase
        end
    endtask

    logic is_cont;
    assign is_cont = (r_mode == M_IDENT)
        ? (f_alpha(i_in_byte) || f_digit(i_in_byte) || i_in_byte == 8'h5f)
        : f_digit(i_in_byte);

    // next state
    always_comb begin
        n_mode = r_mode; n_fl = r_fl; n_wlen = r_wlen; n_slen = r_slen;
        n_depth = r_depth; n_halt = r_halt; n_kwm = r_kwm; n_fkw = r_fkw;
        n_fint = r_fint; n_fidx = r_fidx; n_flen = r_flen; n_pb = r_pb;
        n_peof = r_peof; n_o = r_o;
        n_ov = r_ov && i_out_stall;
        we = 1'b0;
        waddr = r_wlen[AW-1:0];
        wdata = i_in_byte;

        if (r_fl != F_OFF) begin
            // stream buffered word, then the held terminator
            if (r_fl == F_READ) begin
                // first character arrives from the memory next cycle
                n_fl = F_RUN;
            end else if (out_free) begin
                n_ov = 1'b1;
                n_o = mk(r_fkw ? K_KEYWORD : (r_fint ? K_INT : K_IDENT), rdata,
                         r_fidx == r_flen, E_NONE);
                n_fidx = r_fidx + 1'b1;
                if (r_fidx == r_flen) begin
                    n_fl = F_OFF;
                    n_mode = M_IDLE;
                end
            end
        end else if (r_pb != 8'd0 || r_peof) begin
            // replay held terminator after a flush
            if (out_free) begin
                idle_byte(r_pb, r_peof, n_mode, n_halt, n_depth, n_slen, n_wlen, n_kwm,
                          n_ov, n_o, we);
                waddr = '0;
                wdata = r_pb;
                n_pb = 8'd0;
                n_peof = 1'b0;
            end
        end else if (acc && !r_halt) begin
            unique case (r_mode)
                M_IDENT, M_INT: begin
                    if (!i_end_of_input && is_cont) begin
                        if (r_wlen <= LW'(Depth)) begin
                            we = (r_wlen < LW'(Depth));
                            n_kwm = kw_step(r_kwm, r_wlen, i_in_byte);
                            n_wlen = r_wlen + 1'b1;
                        end
                    end else if (r_mode == M_IDENT && r_wlen <= LW'(7)
                                 && kw_hit(r_kwm, r_wlen)) begin
                        n_fl = F_READ; n_fkw = 1'b1; n_fint = 1'b0;
                        n_fidx = '0; n_flen = r_wlen - 1'b1;
                        n_pb = i_end_of_input ? 8'd0 : i_in_byte;
                        n_peof = i_end_of_input;
                    end else if ((r_mode == M_IDENT && r_wlen > LW'(MAX_ID_CHARS))
                                 || (r_mode == M_INT && r_wlen > LW'(MAX_INT_DIGITS))) begin
                        n_halt = 1'b1; n_mode = M_IDLE; n_ov = 1'b1;
                        n_o = mk(K_ERROR, 8'd0, 1'b1,
                                 (r_mode == M_IDENT) ? E_ID_LONG : E_INT_LONG);
                    end else begin
                        n_fl = F_READ; n_fkw = 1'b0; n_fint = (r_mode == M_INT);
                        n_fidx = '0; n_flen = r_wlen - 1'b1;
                        n_pb = i_end_of_input ? 8'd0 : i_in_byte;
                        n_peof = i_end_of_input;
                    end
                    // a NUL terminator replays as a bad character
                    if (n_fl == F_READ && !i_end_of_input && i_in_byte == 8'd0) begin
                        n_pb = 8'd1;
                    end
                end
                M_SLASH: begin
                    if (!i_end_of_input && i_in_byte == 8'h2a) begin
                        n_mode = M_COMMENT;
                    end else begin
                        n_ov = 1'b1; n_o = mk(K_OPER, 8'h2f, 1'b1, E_NONE);
                        n_mode = M_IDLE;
                        n_pb = i_end_of_input ? 8'd0 : i_in_byte;
                        if (!i_end_of_input && i_in_byte == 8'd0) begin
                            n_pb = 8'd1;
                        end
                        n_peof = i_end_of_input;
                    end
                end
                M_COMMENT: begin
                    if (i_end_of_input) begin
                        n_halt = 1'b1; n_mode = M_IDLE; n_ov = 1'b1;
                        n_o = mk(K_ERROR, 8'd0, 1'b1, E_COMMENT);
                    end else if (i_in_byte == 8'h2a) begin
                        n_mode = M_STAR;
                    end
                end
                M_STAR: begin
                    if (!i_end_of_input && i_in_byte == 8'h2f) begin
                        n_mode = M_IDLE;
                    end else begin
                        n_halt = 1'b1; n_mode = M_IDLE; n_ov = 1'b1;
                        n_o = mk(K_ERROR, 8'd0, 1'b1, E_COMMENT);
                    end
                end
                M_STRING: begin
                    n_ov = 1'b1;
                    if (i_end_of_input) begin
                        n_halt = 1'b1; n_mode = M_IDLE;
                        n_o = mk(K_ERROR, 8'd0, 1'b1, E_STR_OPEN);
                    end else if (i_in_byte == 8'h22) begin
                        n_mode = M_IDLE;
                        if (r_slen > SW'(MAX_STR_CHARS)) begin
                            n_halt = 1'b1;
                            n_o = mk(K_ERROR, 8'd0, 1'b1, E_STR_LONG);
                        end else begin
                            n_o = mk(K_STRING, 8'h22, 1'b1, E_NONE);
                        end
                    end else begin
                        if (r_slen <= SW'(MAX_STR_CHARS)) begin
                            n_slen = r_slen + 1'b1;
                        end
                        n_o = mk(K_STRING, i_in_byte, 1'b0, E_NONE);
                    end
                end
                default: begin
                    idle_byte(i_in_byte, i_end_of_input, n_mode, n_halt, n_depth, n_slen,
                              n_wlen, n_kwm, n_ov, n_o, we);
                    waddr = '0;
                end
            endcase
        end

        // read ahead so that rdata holds the character at r_fidx
        raddr = n_fidx[AW-1:0];
    end

    // hold state and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_fl <= F_OFF; r_wlen <= '0; r_slen <= '0;
            r_depth <= '0; r_halt <= 1'b0; r_ov <= 1'b0; r_pb <= 8'd0;
            r_peof <= 1'b0;
        end else begin
            r_mode <= n_mode; r_fl <= n_fl; r_wlen <= n_wlen; r_slen <= n_slen;
            r_depth <= n_depth; r_halt <= n_halt; r_ov <= n_ov; r_pb <= n_pb;
            r_peof <= n_peof;
        end
        r_kwm <= n_kwm; r_fkw <= n_fkw; r_fint <= n_fint; r_fidx <= n_fidx;
        r_flen <= n_flen; r_o <= n_o;
    end

    // a stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_out_stall |=> r_ov && $stable(r_o))
        else $error("output word changed under stall");
    // no input is taken while flushing
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fl != F_OFF |-> o_in_stall)
        else $error("input taken during flush");
    // once halted, stays halted
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt released");
    // error words carry a code
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o.kind == K_ERROR |-> r_o.err != E_NONE)
        else $error("error word without code");
endmodule

// File: test/tb.sv
// Self-checking testbench for token_lexer_with_brace_check_top: a queue of source bytes feeds
// a valid/stall driver, a monitor compares each output word with a local lexer predictor.
// Depends on tlbc_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tlbc_pkg::*;

    localparam int WordDepth = (MaxIdChars > MaxIntDigits) ? MaxIdChars : MaxIntDigits;

    typedef enum logic [2:0] {
        LX_IDLE, LX_IDENT, LX_INT, LX_SLASH, LX_COMMENT, LX_STAR, LX_STRING
    } t_lex;

    typedef struct {
        logic [7:0] b;
        logic       eof;
        logic       drain_first;
    } t_src;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = 8'd0;
    logic       in_eof = 1'b0;
    logic       out_stall = 1'b0;
    logic       o_in_stall, o_out_valid, o_last_char;
    logic [3:0] o_token_kind, o_error_code;
    logic [7:0] o_value_char;

    t_src src_q[$];
    t_tok tok_q[$];
    int   errors = 0;
    int   gap_cnt = 0;
    int   stall_cnt = 0;
    int   sent = 0;
    bit   calm = 1'b0;
    int   gen_depth = 0;

    // predictor state
    t_lex       lx_mode = LX_IDLE;
    logic [7:0] lx_buf[WordDepth];
    int         lx_len = 0;
    int         lx_strlen = 0;
    int         lx_depth = 0;
    bit         lx_halted = 1'b0;
    string      kw_list[8] = '{"int", "text", "is", "loop", "times", "read", "write", "newLine"};

    token_lexer_with_brace_check_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_in_byte(in_byte), .i_end_of_input(in_eof),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_token_kind(o_token_kind), .o_value_char(o_value_char),
        .o_last_char(o_last_char), .o_error_code(o_error_code)
    );

    always #1 i_clk = ~i_clk;

    function automatic void push_tok(t_kind k, logic [7:0] c, logic l, t_err e);
        t_tok t;
        t.kind = k; t.ch = c; t.last = l; t.err = e;
        tok_q.push_back(t);
    endfunction

    function automatic void lex_fail(t_err e);
        lx_halted = 1'b1;
        lx_mode = LX_IDLE;
        push_tok(K_ERROR, 8'd0, 1'b1, e);
    endfunction

    function automatic bit word_is_keyword();
        bit hit;
        for (int k = 0; k < 8; k++) begin
            if (kw_list[k].len() == lx_len) begin
                hit = 1'b1;
                for (int i = 0; i < lx_len; i++)
                    if (lx_buf[i] != kw_list[k][i]) hit = 1'b0;
                if (hit) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Emit a buffered word, or the length error
    function automatic void flush_word();
        t_kind k;
        if (lx_mode == LX_IDENT) begin
            if (lx_len <= 7 && word_is_keyword()) k = K_KEYWORD;
            else if (lx_len > MaxIdChars) begin lex_fail(E_ID_LONG); return; end
            else k = K_IDENT;
        end else begin
            if (lx_len > MaxIntDigits) begin lex_fail(E_INT_LONG); return; end
            k = K_INT;
        end
        for (int i = 0; i < lx_len && i < WordDepth; i++)
            push_tok(k, lx_buf[i], i + 1 == lx_len, E_NONE);
        lx_mode = LX_IDLE;
    endfunction

    // Work out the output words that one accepted input word causes
    function automatic void lex_predict(logic [7:0] b, logic eof);
        bit cont;
        if (lx_halted) return;
        case (lx_mode)
            LX_IDENT, LX_INT: begin
                cont = (lx_mode == LX_IDENT) ? (f_alpha(b) || f_digit(b) || b == "_") : f_digit(b);
                if (!eof && cont) begin
                    if (lx_len <= WordDepth) begin
                        if (lx_len < WordDepth) lx_buf[lx_len] = b;
                        lx_len++;
                    end
                    return;
                end
                flush_word();
                if (lx_halted) return;
            end
            LX_SLASH: begin
                if (!eof && b == "*") begin lx_mode = LX_COMMENT; return; end
                push_tok(K_OPER, "/", 1'b1, E_NONE);
                lx_mode = LX_IDLE;
            end
            LX_COMMENT: begin
                if (eof) lex_fail(E_COMMENT);
                else if (b == "*") lx_mode = LX_STAR;
                return;
            end
            LX_STAR: begin
                if (!eof && b == "/") lx_mode = LX_IDLE;
                else lex_fail(E_COMMENT);
                return;
            end
            LX_STRING: begin
                if (eof) lex_fail(E_STR_OPEN);
                else if (b == "\"") begin
                    if (lx_strlen > MaxStrChars) lex_fail(E_STR_LONG);
                    else begin
                        lx_mode = LX_IDLE;
                        push_tok(K_STRING, b, 1'b1, E_NONE);
                    end
                end else begin
                    if (lx_strlen <= MaxStrChars) lx_strlen++;
                    push_tok(K_STRING, b, 1'b0, E_NONE);
                end
                return;
            end
            default: lx_mode = LX_IDLE;
        endcase
        if (eof) begin
            if (lx_depth != 0) lex_fail(E_BRACE);
            else begin
                lx_halted = 1'b1;
                push_tok(K_END, 8'd0, 1'b1, E_NONE);
            end
            return;
        end
        if (f_space(b)) return;
        if (f_alpha(b) || f_digit(b)) begin
            lx_mode = f_alpha(b) ? LX_IDENT : LX_INT;
            lx_buf[0] = b;
            lx_len = 1;
            return;
        end
        case (b)
            "/": lx_mode = LX_SLASH;
            "+", "-", "*": push_tok(K_OPER, b, 1'b1, E_NONE);
            "{": begin
                if (lx_depth >= MaxNesting) lex_fail(E_NEST);
                else begin lx_depth++; push_tok(K_LBRACE, b, 1'b1, E_NONE); end
            end
            "}": begin
                if (lx_depth == 0) lex_fail(E_BRACE);
                else begin lx_depth--; push_tok(K_RBRACE, b, 1'b1, E_NONE); end
            end
            "\"": begin
                lx_strlen = 0;
                lx_mode = LX_STRING;
                push_tok(K_STRING, b, 1'b0, E_NONE);
            end
            ".": push_tok(K_EOL, b, 1'b1, E_NONE);
            ",": push_tok(K_COMMA, b, 1'b1, E_NONE);
            default: lex_fail(E_BAD_CHAR);
        endcase
    endfunction

    function automatic void put(logic [7:0] b, logic eof = 1'b0, logic drain = 1'b0);
        t_src s;
        s.b = b; s.eof = eof; s.drain_first = drain;
        src_q.push_back(s);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
    endfunction

    function automatic logic [7:0] rand_alpha();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7a))
                                    : 8'($urandom_range(8'h41, 8'h5a));
    endfunction

    function automatic void put_ident(int n);
        int r;
        put(rand_alpha());
        for (int i = 1; i < n; i++) begin
            r = $urandom_range(0, 3);
            if (r == 0) put(8'($urandom_range(8'h30, 8'h39)));
            else if (r == 1) put("_");
            else put(rand_alpha());
        end
    endfunction

    function automatic void put_int(int n);
        for (int i = 0; i < n; i++) put(8'($urandom_range(8'h30, 8'h39)));
    endfunction

    function automatic void put_string_body(int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            do c = 8'($urandom_range(0, 255)); while (c == "\"");
            put(c);
        end
    endfunction

    // One well-formed token with random content, then a separator
    function automatic void put_token();
        int   r;
        logic [7:0] c;
        r = $urandom_range(0, 11);
        case (r)
            0, 1, 2: begin
                if (r == 0) put_text(kw_list[$urandom_range(0, 7)]);
                else if (r == 1) put_ident($urandom_range(1, MaxIdChars));
                else put_int($urandom_range(1, MaxIntDigits));
                // a terminator that is itself a token
                if ($urandom_range(0, 2) == 0) put(",");
            end
            3: begin
                put("\"");
                put_string_body($urandom_range(0, 12));
                put("\"");
            end
            4: begin
                put("/"); put("*");
                for (int i = $urandom_range(0, 10); i > 0; i--) begin
                    do c = 8'($urandom_range(0, 255)); while (c == "*");
                    put(c);
                end
                put("*"); put("/");
            end
            5: put("/");
            6: begin put("{"); gen_depth++; end
            7: if (gen_depth > 0) begin put("}"); gen_depth--; end else put(".");
            8: put(".");
            9: put(",");
            default: put($urandom_range(0, 1) ? "+" : ($urandom_range(0, 1) ? "-" : "*"));
        endcase
        put(rand_space());
    endfunction

    function automatic void close_braces();
        while (gen_depth > 0) begin put("}"); gen_depth--; end
    endfunction

    // Finish the source text by one of the ways the lexer can stop
    function automatic void put_ending(int choice);
        logic [7:0] bad[6] = '{"#", 8'd0, 8'd127, 8'd128, 8'd255, "\"" };
        case (choice)
            0: begin close_braces(); put(8'($urandom), 1'b1); end
            1: begin put_ident(MaxIdChars + $urandom_range(1, 3)); put(rand_space()); end
            2: begin put_int(MaxIntDigits + $urandom_range(1, 3)); put("."); end
            3: begin put("/"); put("*"); put("a"); put("*"); put("x"); end
            4: begin put("/"); put("*"); put("a"); put(8'($urandom), 1'b1); end
            5: begin put("\""); put_string_body(3); put(8'($urandom), 1'b1); end
            6: begin put("\""); put_string_body(MaxStrChars + 1); put("\""); end
            7: put(bad[$urandom_range(0, 4)]);
            8: begin close_braces(); put("}"); end
            9: begin if (gen_depth == 0) put("{"); put(8'($urandom), 1'b1); end
            default: while (gen_depth <= MaxNesting) begin put("{"); gen_depth++; end
        endcase
        // words after the stop are taken but give nothing
        for (int i = 0; i < 4; i++) put(8'($urandom), 1'($urandom));
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Driver: present the next word once the gap is served
    always @(posedge i_clk) begin
        logic nv;
        t_src it;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nv = in_valid;
            if (in_valid && !o_in_stall) begin
                lex_predict(in_byte, in_eof);
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (src_q.size() > 0 && (!src_q[0].drain_first || tok_q.size() == 0)) begin
                    it = src_q.pop_front();
                    in_byte <= it.b;
                    in_eof <= it.eof;
                    nv = 1'b1;
                    sent++;
                    if (sent % 40 == 0) calm = ~calm;
                    gap_cnt = calm ? 0 : $urandom_range(0, 8);
                end
            end
            in_valid <= nv;
        end
    end

    // Monitor: check each taken word against the oldest expectation
    always @(posedge i_clk) begin
        t_tok t;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (tok_q.size() == 0) begin
                    report($sformatf("unexpected word kind %0d char %0h", o_token_kind, o_value_char));
                end else begin
                    t = tok_q.pop_front();
                    if (o_token_kind != t.kind)
                        report($sformatf("kind %0d, want %0d", o_token_kind, t.kind));
                    if (o_value_char != t.ch)
                        report($sformatf("char %0h, want %0h", o_value_char, t.ch));
                    if (o_last_char != t.last)
                        report($sformatf("last %0b, want %0b", o_last_char, t.last));
                    if (o_error_code != t.err)
                        report($sformatf("error %0d, want %0d", o_error_code, t.err));
                end
                stall_cnt = calm ? 0 : $urandom_range(0, 8);
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int ending;
        int fill;
        // pick the stop first: the long stops leave room for less random text
        ending = $urandom_range(0, 10);
        fill = (ending == 6 || ending == 10) ? 70 : 300;
        // directed text: every token, keywords, high bytes in a string and a comment
        put_text("int text{is \"");
        put(8'hff); put(8'h80);
        put_text("\"}/*");
        put(8'h7f);
        put_text("*/loop,9 times-read.write+newLine*a/b");
        put(rand_space(), 1'b0, 1'b1);
        while (src_q.size() < fill - 40) put_token();
        put("x", 1'b0, 1'b1);
        put(" ");
        while (src_q.size() < fill) put_token();
        put_ending(ending);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (src_q.size() > 0 || in_valid) @(posedge i_clk);
        while (tok_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (tok_q.size() == 0 && errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (tok_q.size() != 0) report("expected words left over");
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
